@@ rtl/drlm_pkg.sv @@
// Shared types, constants and helpers for the delta-R list matcher.
// No dependencies; imported by the top level.
package drlm_pkg;

    typedef logic [1:0]         t_action;
    typedef logic signed [14:0] t_q12;
    typedef logic [14:0]        t_mag;
    typedef logic [14:0]        t_thr;
    typedef logic [29:0]        t_sq;
    typedef logic [5:0]         t_index;

    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_APPEND = 2'd1;
    localparam t_action ACT_QUERY  = 2'd2;

    // 2*pi in Q3.12, rounded to nearest.
    localparam logic [15:0] TWO_PI_Q12 = 16'd25736;

    // Square of the reset radius (410 * 410).
    localparam t_sq THR2_RESET = 30'd168100;

    // Magnitude of a 16-bit two's complement difference that never reaches -32768.
    function automatic t_mag abs_mag(input logic [15:0] v);
        logic [15:0] n;
        n = v[15] ? (~v + 16'd1) : v;
        return n[14:0];
    endfunction

endpackage

@@ rtl/drlm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module drlm_ram #(
    parameter int WIDTH  = 30,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/delta_r_list_matcher.sv @@
// A query walks the stored list through a four-stage distance pipeline fed by one RAM read
// per cycle until a hit or the end of the list; the first match, or none, is delivered, and
// a finished result waits while the output is stalled. The input stalls for the whole query.
// Synchronous active-low reset empties the list, clears the overflow flag and sets the
// radius to 410; the entry RAM itself is not cleared. Uses drlm_pkg and drlm_ram.
module delta_r_list_matcher #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  drlm_pkg::t_thr         i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  drlm_pkg::t_action      i_action,
    input  drlm_pkg::t_q12         i_obj_eta,
    input  drlm_pkg::t_q12         i_obj_phi,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_matched,
    output drlm_pkg::t_index       o_match_index,
    output logic                   o_list_overflow
);
    import drlm_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_ovf, n_ovf;
    t_sq           r_thr2;
    t_q12          r_q_eta, r_q_phi;

    // Pipeline valids and entry tags, one per stage.
    logic          r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0] r_k1, r_k2, r_k3, r_k4;
    t_mag          r_de2, r_d2, r_de3, r_dp3;
    t_sq           r_sq_e, r_sq_p;

    logic          r_res_hit, n_res_hit;
    logic [AW-1:0] r_res_idx, n_res_idx;

    logic          r_out_valid, n_out_valid;
    logic          r_matched;
    t_index        r_match_index;
    logic          r_list_ovf;

    logic          accept;
    logic          ram_we;
    logic [29:0]   ram_rdata;
    t_q12          rd_eta, rd_phi;
    logic [15:0]   eta_diff, phi_diff, wrap_diff;
    t_mag          de_a, d_a, w_b, dp_b;
    logic [30:0]   r2_sum;
    logic          hit, none_left, issue, load_out;

    assign accept = i_in_valid && !o_in_stall;
    assign ram_we = accept && (i_action == ACT_APPEND) && (r_count < FULL);

    drlm_ram #(
        .WIDTH  (30),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_obj_eta, i_obj_phi}),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_eta = ram_rdata[29:15];
    assign rd_phi = ram_rdata[14:0];

    // Stage A: absolute eta and phi differences.
    assign eta_diff = {r_q_eta[14], r_q_eta} - {rd_eta[14], rd_eta};
    assign phi_diff = {r_q_phi[14], r_q_phi} - {rd_phi[14], rd_phi};
    assign de_a     = abs_mag(eta_diff);
    assign d_a      = abs_mag(phi_diff);

    // Stage B: wrap the azimuth difference around 2pi and keep the shorter way.
    assign wrap_diff = TWO_PI_Q12 - {1'b0, r_d2};
    assign w_b       = abs_mag(wrap_diff);
    assign dp_b      = (w_b < r_d2) ? w_b : r_d2;

    // Stage D: squared distance against squared radius.
    assign r2_sum    = {1'b0, r_sq_e} + {1'b0, r_sq_p};
    assign hit       = r_v4 && (r2_sum < {1'b0, r_thr2});
    assign none_left = (r_ptr == r_count) && !r_v1 && !r_v2 && !r_v3 && !r_v4;
    assign issue     = (r_state == ST_RUN) && !hit && (r_ptr != r_count);
    assign load_out  = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_ovf       = r_ovf;
        n_res_hit   = r_res_hit;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        ACT_APPEND: begin
                            if (r_count < FULL) begin
                                n_count = r_count + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            n_ptr   = '0;
                            n_state = ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (hit) begin
                    n_res_hit = 1'b1;
                    n_res_idx = r_k4;
                    n_state   = ST_DONE;
                end else if (none_left) begin
                    n_res_hit = 1'b0;
                    n_res_idx = '0;
                    n_state   = ST_DONE;
                end else if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_ovf       <= 1'b0;
            r_thr2      <= THR2_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_res_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_ovf       <= n_ovf;
            r_res_hit   <= n_res_hit;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr2 <= 30'(i_cfg_wdata) * 30'(i_cfg_wdata);
            end
            // Words behind a hit are dropped by clearing the valids.
            if ((r_state == ST_RUN) && !hit) begin
                r_v1 <= issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end else begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
                r_v3 <= 1'b0;
                r_v4 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q_eta <= i_obj_eta;
            r_q_phi <= i_obj_phi;
        end
        r_k1      <= r_ptr[AW-1:0];
        r_k2      <= r_k1;
        r_k3      <= r_k2;
        r_k4      <= r_k3;
        r_de2     <= de_a;
        r_d2      <= d_a;
        r_de3     <= r_de2;
        r_dp3     <= dp_b;
        r_sq_e    <= 30'(r_de3) * 30'(r_de3);
        r_sq_p    <= 30'(r_dp3) * 30'(r_dp3);
        r_res_idx <= n_res_idx;
        if (load_out) begin
            r_matched     <= r_res_hit;
            r_match_index <= 6'(r_res_idx);
            r_list_ovf    <= r_ovf;
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_matched       = r_matched;
    assign o_match_index   = r_match_index;
    assign o_list_overflow = r_list_ovf;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for delta_r_list_matcher: clear, append and query words with random
// input gaps and output stalls, every query answer predicted here and checked as it arrives.
// Depends on drlm_pkg and the delta_r_list_matcher top level.
module tb;
    import drlm_pkg::*;

    localparam int LIST_DEPTH     = 64;
    localparam int PHI_PERIOD     = 25736;
    localparam int PI_Q12         = 12868;
    localparam int DRAIN_CYCLES   = LIST_DEPTH + 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam t_action ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic   matched;
        t_index index;
        logic   overflow;
    } t_match_result;

    logic    i_clk           = 1'b0;
    logic    i_rst_n         = 1'b0;
    logic    i_cfg_we        = 1'b0;
    t_thr    i_cfg_wdata     = '0;
    logic    i_in_valid      = 1'b0;
    logic    o_in_stall;
    t_action i_action        = ACT_CLEAR;
    t_q12    i_obj_eta       = '0;
    t_q12    i_obj_phi       = '0;
    logic    o_out_valid;
    logic    i_out_stall     = 1'b0;
    logic    o_matched;
    t_index  o_match_index;
    logic    o_list_overflow;

    // Expected contents of the block's list, its overflow flag and its radius.
    t_q12 list_eta [LIST_DEPTH];
    t_q12 list_phi [LIST_DEPTH];
    int   list_count   = 0;
    logic list_dropped = 1'b0;
    t_thr radius_q12   = 15'd410;

    t_match_result pending_matches[$];
    int error_count  = 0;
    int sent_words   = 0;
    int idle_cycles  = 0;
    bit gaps_on      = 1'b0;
    bit stalls_on    = 1'b0;

    delta_r_list_matcher i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_obj_eta      (i_obj_eta),
        .i_obj_phi      (i_obj_phi),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_matched      (o_matched),
        .o_match_index  (o_match_index),
        .o_list_overflow(o_list_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_q12 any_q12();
        logic [31:0] r;
        r = $urandom();
        return r[14:0];
    endfunction

    function automatic t_q12 rand_eta();
        int v;
        if ($urandom_range(0, 1) == 0) return any_q12();
        v = int'($urandom_range(0, 2000)) - 1000;
        return t_q12'(v);
    endfunction

    function automatic t_q12 rand_phi();
        int v;
        if ($urandom_range(0, 99) < 15) return any_q12();
        v = int'($urandom_range(0, 2 * PI_Q12)) - PI_Q12;
        return t_q12'(v);
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Squared distance against the squared radius, with the azimuth difference folded
    // to the shorter way around the circle.
    function automatic bit within_radius(t_q12 eta, t_q12 phi, int k);
        longint de, d, w, dp;
        de = longint'(eta) - longint'(list_eta[k]);
        if (de < 0) de = -de;
        d = longint'(phi) - longint'(list_phi[k]);
        if (d < 0) d = -d;
        w = PHI_PERIOD - d;
        if (w < 0) w = -w;
        dp = (w < d) ? w : d;
        return (de * de + dp * dp) < (longint'(radius_q12) * longint'(radius_q12));
    endfunction

    function automatic void predict_word(t_action act, t_q12 eta, t_q12 phi);
        t_match_result res;
        case (act)
            ACT_CLEAR: begin
                list_count   = 0;
                list_dropped = 1'b0;
            end
            ACT_APPEND: begin
                if (list_count < LIST_DEPTH) begin
                    list_eta[list_count] = eta;
                    list_phi[list_count] = phi;
                    list_count++;
                end else begin
                    list_dropped = 1'b1;
                end
            end
            ACT_QUERY: begin
                res = '0;
                for (int k = 0; k < list_count; k++) begin
                    if (!res.matched && within_radius(eta, phi, k)) begin
                        res.matched = 1'b1;
                        res.index   = t_index'(k);
                    end
                end
                res.overflow = list_dropped;
                pending_matches.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Valid is left high on return; the next word or wait_idle decides what it does next.
    task automatic send_word(t_action act, t_q12 eta, t_q12 phi);
        int gap;
        gap = gaps_on ? idle_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_obj_eta  <= eta;
        i_obj_phi  <= phi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(act, eta, phi);
        if (act != ACT_UNUSED) sent_words++;
    endtask

    // Clears and appends give no result, so the block gets a full query time on top.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_radius(t_thr value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        radius_q12 = value;
    endtask

    // Mostly a query close to a stored entry, sometimes shifted a full turn in azimuth, else random.
    task automatic send_query_near();
        int   k, span, p;
        t_q12 eta, phi;
        if (list_count == 0 || $urandom_range(0, 4) == 0) begin
            send_word(ACT_QUERY, rand_eta(), rand_phi());
            return;
        end
        k    = $urandom_range(0, list_count - 1);
        span = (radius_q12 > 3000) ? 3000 : int'(radius_q12) + 2;
        eta  = t_q12'(int'(list_eta[k]) + jitter(span));
        p    = int'(list_phi[k]) + jitter(span);
        if ($urandom_range(0, 3) == 0) p = (p > 0) ? p - PHI_PERIOD : p + PHI_PERIOD;
        phi  = t_q12'(p);
        send_word(ACT_QUERY, eta, phi);
    endtask

    task automatic send_sequence();
        int r, n_append, n_query;
        if ($urandom_range(0, 99) < 70) send_word(ACT_CLEAR, any_q12(), any_q12());
        r = $urandom_range(0, 99);
        if (r < 80)      n_append = $urandom_range(0, 10);
        else if (r < 95) n_append = $urandom_range(11, 40);
        else             n_append = $urandom_range(60, 70);
        repeat (n_append) send_word(ACT_APPEND, rand_eta(), rand_phi());
        n_query = $urandom_range(1, 8);
        repeat (n_query) begin
            r = $urandom_range(0, 99);
            if (r < 5)       send_word(ACT_UNUSED, any_q12(), any_q12());
            else if (r < 10) send_word(t_action'($urandom_range(0, 3)), any_q12(), any_q12());
            else             send_query_near();
        end
    endtask

    // Reset radius of 410: empty list, field extremes, the strict edge, the phi wrap.
    task automatic test_reset_radius();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_word(ACT_QUERY, 15'sd0, 15'sd0);
        send_word(ACT_APPEND, -15'sd16384, -15'sd12868);
        send_word(ACT_APPEND, 15'sd16383, 15'sd12868);
        send_word(ACT_APPEND, 15'sd0, 15'sd0);
        send_word(ACT_QUERY, 15'sd0, 15'sd409);
        send_word(ACT_QUERY, 15'sd0, 15'sd410);
        send_word(ACT_QUERY, 15'sd290, 15'sd289);
        send_word(ACT_QUERY, 15'sd300, 15'sd280);
        send_word(ACT_QUERY, 15'sd16383, -15'sd12868);
        send_word(ACT_UNUSED, 15'sd1, 15'sd1);
        send_word(ACT_QUERY, -15'sd16384, 15'sd16383);
        send_word(ACT_CLEAR, -15'sd1, -15'sd1);
        send_word(ACT_QUERY, 15'sd0, 15'sd0);
    endtask

    // Zero radius never matches; the largest matches almost anything; radius one only itself.
    task automatic test_radius_extremes();
        set_radius(15'd0);
        send_word(ACT_APPEND, 15'sd0, 15'sd0);
        send_word(ACT_QUERY, 15'sd0, 15'sd0);
        set_radius(15'd32767);
        send_word(ACT_QUERY, 15'sd16383, 15'sd12868);
        send_word(ACT_QUERY, -15'sd16384, -15'sd16384);
        set_radius(15'd1);
        send_word(ACT_QUERY, 15'sd0, 15'sd0);
        send_word(ACT_QUERY, 15'sd0, 15'sd1);
    endtask

    // Fill the list to capacity, then push past it and clear the flag again.
    task automatic test_list_overflow();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_word(ACT_CLEAR, any_q12(), any_q12());
        repeat (LIST_DEPTH) send_word(ACT_APPEND, rand_eta(), rand_phi());
        send_word(ACT_QUERY, list_eta[LIST_DEPTH - 1], list_phi[LIST_DEPTH - 1]);
        send_word(ACT_QUERY, rand_eta(), rand_phi());
        repeat (3) send_word(ACT_APPEND, rand_eta(), rand_phi());
        send_word(ACT_QUERY, list_eta[0], list_phi[0]);
        send_word(ACT_QUERY, rand_eta(), rand_phi());
        send_word(ACT_CLEAR, any_q12(), any_q12());
        send_word(ACT_QUERY, rand_eta(), rand_phi());
    endtask

    task automatic test_random_traffic(t_thr radius, int words, bit with_gaps, bit with_stalls);
        int stop_at;
        set_radius(radius);
        gaps_on   = with_gaps;
        stalls_on = with_stalls;
        stop_at   = sent_words + words;
        while (sent_words < stop_at) send_sequence();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_radius();
        test_radius_extremes();
        test_list_overflow();
        test_random_traffic(15'd410, 400, 1'b1, 1'b1);
        test_random_traffic(t_thr'($urandom_range(200, 1500)), 350, 1'b1, 1'b1);
        test_random_traffic(15'd32767, 200, 1'b1, 1'b1);
        test_random_traffic(15'd0, 100, 1'b1, 1'b0);
        test_random_traffic(t_thr'($urandom_range(0, 32767)), 250, 1'b0, 1'b0);
        test_random_traffic(t_thr'($urandom_range(1, 800)), 400, 1'b1, 1'b1);
        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output stall in runs; the short free runs keep results moving between stalls.
    initial begin : out_stall_gen
        int   run;
        logic stall_now;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (run > 0) begin
                run--;
            end else begin
                stall_now = stalls_on && ($urandom_range(0, 2) == 0);
                run = stall_now ? idle_length() : $urandom_range(0, 5);
                i_out_stall <= stall_now;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_match_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_matches.size() == 0) begin
                $error("Result word with none expected: matched=%0b index=%0d overflow=%0b",
                       o_matched, o_match_index, o_list_overflow);
                error_count++;
            end else begin
                want = pending_matches.pop_front();
                if (o_matched !== want.matched) begin
                    $error("matched: expected %0b, got %0b", want.matched, o_matched);
                    error_count++;
                end
                if (o_match_index !== want.index) begin
                    $error("match_index: expected %0d, got %0d", want.index, o_match_index);
                    error_count++;
                end
                if (o_list_overflow !== want.overflow) begin
                    $error("list_overflow: expected %0b, got %0b", want.overflow,
                           o_list_overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
rtl/drlm_pkg.sv
rtl/drlm_ram.sv
rtl/delta_r_list_matcher.sv
tb/tb.sv
